/* rtl/cwm_pkg.sv */
// shared types and constants of the clamped window median filter
package cwm_pkg;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SETUP,
        S_SWEEP,
        S_FLUSH,
        S_DECIDE,
        S_EMIT
    } state_t;

    // input word kinds carried in tuser
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // fixed field widths
    localparam int CFG_W   = 13;
    localparam int CHAN_W  = 8;
    localparam int PIXEL_W = 32;

    // control from the sequencer to the bit select unit
    typedef struct packed {
        logic       start;
        logic       acc;
        logic       decide;
        logic [2:0] bitpos;
    } sel_ctrl_t;

endpackage

/* rtl/cwm_line_store.sv */
// line store memory: one write port, one registered read port
module cwm_line_store
    import cwm_pkg::*;
#(
    parameter int DEPTH  = 20480,
    parameter int ADDR_W = 15
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [PIXEL_W-1:0] wdata,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [PIXEL_W-1:0] rdata
);

    logic [PIXEL_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/cwm_bit_select.sv */
// bit-serial rank select: one median bit per window sweep for red, green and blue
module cwm_bit_select
    import cwm_pkg::*;
#(
    parameter int CNT_W = 9
)
(
    input  logic               clk,
    input  sel_ctrl_t          ctrl,
    input  logic [CNT_W-1:0]   win_count,
    input  logic [PIXEL_W-1:0] pixel,
    output logic [CHAN_W-1:0]  median_red,
    output logic [CHAN_W-1:0]  median_green,
    output logic [CHAN_W-1:0]  median_blue
);

    logic [CHAN_W-1:0] bit_mask;
    logic [CHAN_W-1:0] high_mask;

    // masks for the bit under decision and the bits already settled
    assign bit_mask  = CHAN_W'(1) << ctrl.bitpos;
    assign high_mask = {CHAN_W{1'b1}} << (4'(ctrl.bitpos) + 4'd1);

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        logic [CHAN_W-1:0] prefix_reg;
        logic [CNT_W-1:0]  rank_reg;
        logic [CNT_W-1:0]  count_reg;
        logic [CHAN_W-1:0] sample;
        logic              match;

        assign sample = pixel[CHAN_W*ch +: CHAN_W];
        // sample agrees with the settled prefix and has a zero at this bit
        assign match  = ((sample & high_mask) == (prefix_reg & high_mask))
                        && ((sample & bit_mask) == '0);

        // count zeros under the prefix, then settle one bit
        always_ff @(posedge clk)
        begin
            if (ctrl.start)
            begin
                rank_reg   <= (win_count - CNT_W'(1)) >> 1;
                prefix_reg <= '0;
                count_reg  <= '0;
            end
            else if (ctrl.decide)
            begin
                if (count_reg <= rank_reg)
                begin
                    prefix_reg <= prefix_reg | bit_mask;
                    rank_reg   <= rank_reg - count_reg;
                end
                count_reg <= '0;
            end
            else if (ctrl.acc && match)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    assign median_red   = g_lane[0].prefix_reg;
    assign median_green = g_lane[1].prefix_reg;
    assign median_blue  = g_lane[2].prefix_reg;

endmodule

/* rtl/clamped_window_median_rgb.sv */
// top level of the clamped window rgb median filter
// Pixels enter in raster order as push words (tuser 0) and are stored in a line
// store of 2*MAX_RADIUS rows; drain words (tuser 1) only ask for a result.
// After each input word the block checks whether the window of the next output
// position has fully arrived; if not, it goes back to idle and is ready again.
// If so, it scans the clamped window through the single read port of the line
// store once per median bit, eight times, settling red, green and blue one bit
// per scan, for a window of up to (2*MAX_RADIUS-1)^2 pixels. Results leave
// through an output register in raster order with tlast on each row end and
// tuser on the frame end. A configuration write to the width, height or radius
// register restarts the frame.
module clamped_window_median_rgb
    import cwm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 10,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
    input  logic             s_axis_tuser,   // command
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic             m_axis_tlast,
    output logic             m_axis_tuser,   // frame_end
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int STORE_ROWS = 2 * MAX_RADIUS;
    localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int SLOT_W     = $clog2(STORE_ROWS);
    localparam int COL_W      = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
    localparam int DIM_W      = $clog2(2 * MAX_RADIUS);
    localparam int CNT_W      = $clog2((2 * MAX_RADIUS - 1) * (2 * MAX_RADIUS - 1) + 1);

    state_t state_reg, state_next;

    logic [10:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [3:0]  window_radius_reg;

    logic [ROW_W-1:0]  in_row_reg, out_row_reg, win_r0_reg, win_r1_reg, row_reg;
    logic [COL_W-1:0]  in_col_reg, out_col_reg, win_c0_reg, win_c1_reg, col_reg;
    logic [SLOT_W-1:0] in_slot_reg, out_slot_reg, slot0_reg, slot_reg;
    logic [ADDR_W-1:0] base0_reg, base_reg;
    logic [DIM_W-1:0]  dim_r_reg, dim_c_reg;
    logic              in_done_reg;
    logic              acc_reg;
    logic [2:0]        bit_reg;
    logic [7:0]        alpha_reg;

    logic              out_valid_reg;
    logic [31:0]       out_data_reg;
    logic              out_last_reg, out_frame_reg;

    // effective configuration, clamped to the supported range
    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [3:0]       reach;

    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = COL_W'(1);
        else if (32'(image_width_reg) > MAX_WIDTH)
            w_eff = COL_W'(MAX_WIDTH);
        else
            w_eff = COL_W'(image_width_reg);

        if (image_height_reg == '0)
            h_eff = ROW_W'(1);
        else if (32'(image_height_reg) > MAX_HEIGHT)
            h_eff = ROW_W'(MAX_HEIGHT);
        else
            h_eff = ROW_W'(image_height_reg);

        if (window_radius_reg == '0)
            reach = 4'd0;
        else if (32'(window_radius_reg) > MAX_RADIUS)
            reach = 4'(MAX_RADIUS - 1);
        else
            reach = window_radius_reg - 4'd1;
    end

    // clamped window of the next output position and its readiness
    logic [ROW_W:0]    nr_sum, r1, r0;
    logic [COL_W:0]    nc_sum, c1, c0;
    logic              win_ready;
    logic [3:0]        row_back;
    logic [SLOT_W:0]   slot0_calc;

    always_comb
    begin
        nr_sum = {1'b0, out_row_reg} + (ROW_W + 1)'(reach);
        nc_sum = {1'b0, out_col_reg} + (COL_W + 1)'(reach);
        r1 = (nr_sum > {1'b0, h_eff - ROW_W'(1)}) ? {1'b0, h_eff - ROW_W'(1)} : nr_sum;
        c1 = (nc_sum > {1'b0, w_eff - COL_W'(1)}) ? {1'b0, w_eff - COL_W'(1)} : nc_sum;
        r0 = ({1'b0, out_row_reg} >= (ROW_W + 1)'(reach))
             ? {1'b0, out_row_reg} - (ROW_W + 1)'(reach) : '0;
        c0 = ({1'b0, out_col_reg} >= (COL_W + 1)'(reach))
             ? {1'b0, out_col_reg} - (COL_W + 1)'(reach) : '0;
        win_ready = in_done_reg || (r1 < {1'b0, in_row_reg})
                    || ((r1 == {1'b0, in_row_reg}) && (c1 < {1'b0, in_col_reg}));
        row_back = 4'({1'b0, out_row_reg} - r0);
        if ((SLOT_W + 1)'(out_slot_reg) >= (SLOT_W + 1)'(row_back))
            slot0_calc = (SLOT_W + 1)'(out_slot_reg) - (SLOT_W + 1)'(row_back);
        else
            slot0_calc = (SLOT_W + 1)'(out_slot_reg) + (SLOT_W + 1)'(STORE_ROWS)
                         - (SLOT_W + 1)'(row_back);
    end

    // handshakes
    logic in_fire, out_free, push_fire, sweep_last;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign push_fire  = in_fire && (s_axis_tuser == CMD_PUSH) && !in_done_reg;
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign sweep_last = (col_reg == win_c1_reg) && (row_reg == win_r1_reg);

    // line store ports
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [PIXEL_W-1:0] rdata;

    assign waddr = ADDR_W'(32'(in_slot_reg) * MAX_WIDTH + 32'(in_col_reg));
    assign raddr = (state_reg == S_CHECK)
                   ? ADDR_W'(32'(out_slot_reg) * MAX_WIDTH + 32'(out_col_reg))
                   : base_reg + ADDR_W'(col_reg);

    cwm_line_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (push_fire),
        .waddr (waddr),
        .wdata (s_axis_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // bit select unit
    sel_ctrl_t        sel_ctrl;
    logic [CNT_W-1:0] win_count;
    logic [7:0]       med_red, med_green, med_blue;

    assign win_count = CNT_W'(32'(dim_r_reg) * 32'(dim_c_reg));

    cwm_bit_select #(
        .CNT_W (CNT_W)
    ) u_select (
        .clk          (clk),
        .ctrl         (sel_ctrl),
        .win_count    (win_count),
        .pixel        (rdata),
        .median_red   (med_red),
        .median_green (med_green),
        .median_blue  (med_blue)
    );

    // next state and unit control
    always_comb
    begin
        state_next      = state_reg;
        sel_ctrl.start  = 1'b0;
        sel_ctrl.acc    = acc_reg;
        sel_ctrl.decide = 1'b0;
        sel_ctrl.bitpos = bit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = win_ready ? S_SETUP : S_IDLE;
            end
            S_SETUP:
            begin
                sel_ctrl.start = 1'b1;
                state_next     = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (sweep_last)
                    state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                sel_ctrl.decide = 1'b1;
                state_next      = (bit_reg == 3'd0) ? S_EMIT : S_SWEEP;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // frame counters and configuration
    logic frame_end;

    assign frame_end = (out_col_reg == w_eff - COL_W'(1)) && (out_row_reg == h_eff - ROW_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= 11'd1024;
            image_height_reg  <= 13'd1024;
            window_radius_reg <= 4'd1;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            in_done_reg  <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
        end
        else if (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                            || cfg_index == REG_RADIUS))
        begin
            unique case (cfg_index)
                REG_WIDTH:  image_width_reg   <= cfg_data[10:0];
                REG_HEIGHT: image_height_reg  <= cfg_data[12:0];
                default:    window_radius_reg <= cfg_data[3:0];
            endcase
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            in_done_reg  <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
        end
        else if (state_reg == S_EMIT && out_free)
        begin
            if (frame_end)
            begin
                in_row_reg   <= '0;
                in_col_reg   <= '0;
                in_slot_reg  <= '0;
                in_done_reg  <= 1'b0;
                out_row_reg  <= '0;
                out_col_reg  <= '0;
                out_slot_reg <= '0;
            end
            else if (out_col_reg == w_eff - COL_W'(1))
            begin
                out_col_reg  <= '0;
                out_row_reg  <= out_row_reg + ROW_W'(1);
                out_slot_reg <= (32'(out_slot_reg) == STORE_ROWS - 1)
                                ? '0 : out_slot_reg + SLOT_W'(1);
            end
            else
            begin
                out_col_reg <= out_col_reg + COL_W'(1);
            end
        end
        else if (push_fire)
        begin
            if (in_col_reg + COL_W'(1) >= w_eff)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= in_row_reg + ROW_W'(1);
                in_slot_reg <= (32'(in_slot_reg) == STORE_ROWS - 1)
                               ? '0 : in_slot_reg + SLOT_W'(1);
                if (in_row_reg + ROW_W'(1) >= h_eff)
                    in_done_reg <= 1'b1;
            end
            else
            begin
                in_col_reg <= in_col_reg + COL_W'(1);
            end
        end
    end

    // window scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 1'b0;
            bit_reg <= 3'd7;
        end
        else
        begin
            acc_reg <= (state_reg == S_SWEEP);
            unique case (state_reg)
                S_CHECK:
                begin
                    win_r0_reg <= ROW_W'(r0);
                    win_r1_reg <= ROW_W'(r1);
                    win_c0_reg <= COL_W'(c0);
                    win_c1_reg <= COL_W'(c1);
                    dim_r_reg  <= DIM_W'(r1 - r0 + (ROW_W + 1)'(1));
                    dim_c_reg  <= DIM_W'(c1 - c0 + (COL_W + 1)'(1));
                    slot0_reg  <= SLOT_W'(slot0_calc);
                    bit_reg    <= 3'd7;
                end
                S_SETUP:
                begin
                    alpha_reg <= rdata[31:24];
                    base0_reg <= ADDR_W'(32'(slot0_reg) * MAX_WIDTH);
                    base_reg  <= ADDR_W'(32'(slot0_reg) * MAX_WIDTH);
                    slot_reg  <= slot0_reg;
                    row_reg   <= win_r0_reg;
                    col_reg   <= win_c0_reg;
                end
                S_SWEEP:
                begin
                    if (col_reg == win_c1_reg)
                    begin
                        col_reg <= win_c0_reg;
                        if (row_reg != win_r1_reg)
                        begin
                            row_reg <= row_reg + ROW_W'(1);
                            if (32'(slot_reg) == STORE_ROWS - 1)
                            begin
                                slot_reg <= '0;
                                base_reg <= '0;
                            end
                            else
                            begin
                                slot_reg <= slot_reg + SLOT_W'(1);
                                base_reg <= base_reg + ADDR_W'(MAX_WIDTH);
                            end
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
                S_DECIDE:
                begin
                    bit_reg  <= bit_reg - 3'd1;
                    slot_reg <= slot0_reg;
                    base_reg <= base0_reg;
                    row_reg  <= win_r0_reg;
                    col_reg  <= win_c0_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_EMIT && out_free)
        begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= {alpha_reg, med_blue, med_green, med_red};
            out_last_reg  <= (out_col_reg == w_eff - COL_W'(1));
            out_frame_reg <= frame_end;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_frame_reg;

`ifndef SYNTHESIS
    // a new result appears only from the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == S_EMIT)
        else $error("result appeared without an emit step");

    // the scan never runs past the last window row
    a_sweep_rows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SWEEP |-> row_reg <= win_r1_reg)
        else $error("window scan beyond last row");

    // every bit decision follows a flushed scan
    a_decide_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECIDE |-> $past(state_reg) == S_FLUSH)
        else $error("bit decided without a complete scan");
`endif

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench of the clamped window rgb median filter
module tb_top
    import cwm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_W     = 1024;
    localparam int RAD_MAX    = 10;
    localparam int HGT_MAX    = 4096;
    localparam int STORE_ROWS = 2 * RAD_MAX;
    localparam int DRAIN_WAIT = 40;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_end;
        logic       frame_end;
    } pix_res_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [12:0] val;
        logic        cmd;
        logic [31:0] px;
        bit          has_exp;
        pix_res_t    exp;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    clamped_window_median_rgb DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // filter model state
    logic [31:0] line_mem [STORE_ROWS*LINE_W];
    logic [10:0] reg_width;
    logic [12:0] reg_height;
    logic [3:0]  reg_radius;
    int          in_row, in_col, out_row, out_col;
    bit          frame_in_done;
    bit          frame_closed;

    pix_res_t    median_q [$];
    int          n_words, n_results, n_frames, n_phases, n_errors;
    bit          hold_req;
    int          burst_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int clamp_i(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void restart_counters();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        frame_in_done = 1'b0;
    endfunction

    function automatic int lower_median(int hist[256], int n);
        int k;
        int seen;
        k = (n - 1) / 2;
        seen = 0;
        for (int v = 0; v < 255; v++)
        begin
            seen += hist[v];
            if (seen > k)
                return v;
        end
        return 255;
    endfunction

    // one input word through the filter model; returns 1 when a result is owed
    function automatic bit median_step(logic cmd, logic [31:0] px, output pix_res_t res);
        int w, h, reach, nr, nc, r0, r1, c0, c1, n;
        int hr [256];
        int hg [256];
        int hb [256];
        logic [31:0] word, centre;
        w = clamp_i(reg_width, 1, LINE_W);
        h = clamp_i(reg_height, 1, HGT_MAX);
        reach = clamp_i(reg_radius, 1, RAD_MAX) - 1;
        res = '0;
        if (cmd == CMD_PUSH && !frame_in_done)
        begin
            line_mem[(in_row % STORE_ROWS) * LINE_W + in_col] = px;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                    frame_in_done = 1'b1;
            end
        end
        if (!frame_in_done)
        begin
            nr = (out_row + reach > h - 1) ? h - 1 : out_row + reach;
            nc = (out_col + reach > w - 1) ? w - 1 : out_col + reach;
            if (!(nr < in_row || (nr == in_row && nc < in_col)))
                return 1'b0;
        end
        r0 = out_row >= reach ? out_row - reach : 0;
        r1 = out_row + reach > h - 1 ? h - 1 : out_row + reach;
        c0 = out_col >= reach ? out_col - reach : 0;
        c1 = out_col + reach > w - 1 ? w - 1 : out_col + reach;
        for (int v = 0; v < 256; v++)
        begin
            hr[v] = 0;
            hg[v] = 0;
            hb[v] = 0;
        end
        for (int r = r0; r <= r1; r++)
            for (int c = c0; c <= c1; c++)
            begin
                word = line_mem[(r % STORE_ROWS) * LINE_W + c];
                hr[word[7:0]]++;
                hg[word[15:8]]++;
                hb[word[23:16]]++;
            end
        n = (r1 - r0 + 1) * (c1 - c0 + 1);
        centre = line_mem[(out_row % STORE_ROWS) * LINE_W + out_col];
        res.red = 8'(lower_median(hr, n));
        res.green = 8'(lower_median(hg, n));
        res.blue = 8'(lower_median(hb, n));
        res.alpha = centre[31:24];
        res.row_end = (out_col == w - 1);
        res.frame_end = (out_col == w - 1) && (out_row == h - 1);
        if (res.frame_end)
        begin
            restart_counters();
            frame_closed = 1'b1;
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
        return 1'b1;
    endfunction

    // offer one word and wait for it to be taken; bursts with random gaps
    task automatic send_word(logic cmd, logic [31:0] px, bit has_exp = 0,
                             pix_res_t exp = '0);
        pix_res_t res;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= px;
        do @(posedge clk); while (!s_axis_tready);
        n_words++;
        if (median_step(cmd, px, res))
            median_q.push_back(has_exp ? exp : res);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
    endtask

    // let every owed result leave and the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (median_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH:
            begin
                reg_width = val[10:0];
                restart_counters();
            end
            REG_HEIGHT:
            begin
                reg_height = val;
                restart_counters();
            end
            REG_RADIUS:
            begin
                reg_radius = val[3:0];
                restart_counters();
            end
            default: ;
        endcase
    endtask

    function automatic stim_row_t cfg_row(logic [1:0] idx, logic [12:0] val);
        stim_row_t s;
        s = '{1'b1, idx, val, CMD_PUSH, 32'h0, 1'b0, pix_res_t'(0)};
        return s;
    endfunction

    function automatic stim_row_t word_row(logic cmd, logic [31:0] px, bit has_exp = 0,
                                          pix_res_t exp = '0);
        stim_row_t s;
        s = '{1'b0, REG_WIDTH, 13'h0, cmd, px, has_exp, exp};
        return s;
    endfunction

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return {8'($urandom), 24'($urandom_range(0, 3) * 24'h010101)};
            default: return $urandom;
        endcase
    endfunction

    // receiver: own stall pattern plus one long hold-off on request
    int rx_mode, rx_hold, rx_cnt;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_mode = 0;
            rx_hold = 0;
            rx_cnt = 0;
        end
        else
        begin
            if (rx_cnt == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_cnt = $urandom_range(16, 128);
            end
            rx_cnt--;
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                rx_hold = HOLD_LEN;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
                    2:       m_axis_tready <= ($urandom_range(0, 9) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result checker
    pix_res_t got, want;
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                   m_axis_tdata[31:24], m_axis_tlast, m_axis_tuser};
            n_results++;
            if (median_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected result %h at %0t", got, $realtime);
            end
            else
            begin
                want = median_q.pop_front();
                if (want.frame_end)
                    n_frames++;
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.alpha !== want.alpha ||
                    got.row_end !== want.row_end || got.frame_end !== want.frame_end)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"ERROR: result r/g/b/a/last/end expected",
                                  " %h %h %h %h %b %b got %h %h %h %h %b %b"},
                                 want.red, want.green, want.blue, want.alpha, want.row_end,
                                 want.frame_end, got.red, got.green, got.blue, got.alpha,
                                 got.row_end, got.frame_end);
                end
            end
        end
    end

    // run limit
    initial
    begin
        #60ms;
        $display("clamped_window_median_rgb test failed");
        $finish;
    end

    // main sequence
    stim_row_t dir_tab [$];
    initial
    begin
        int w, h, r, frames, cut;
        bit aborted;
        logic cmd;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_PUSH;
        cfg_we        = 1'b0;
        cfg_index     = REG_WIDTH;
        cfg_data      = '0;
        rst_n         = 1'b0;
        hold_req      = 1'b0;
        burst_left    = 0;
        n_words = 0; n_results = 0; n_frames = 0; n_phases = 0; n_errors = 0;
        reg_width = 11'd1024;
        reg_height = 13'd1024;
        reg_radius = 4'd1;
        restart_counters();
        frame_closed = 1'b0;
        foreach (line_mem[i]) line_mem[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: register extremes, single pixel frames, small frame
        dir_tab.push_back(cfg_row(REG_WIDTH, 13'h1FFF));
        dir_tab.push_back(cfg_row(REG_HEIGHT, 13'h1FFF));
        dir_tab.push_back(cfg_row(REG_RADIUS, 13'h1FFF));
        dir_tab.push_back(word_row(CMD_PUSH, 32'h1234_5678));
        dir_tab.push_back(word_row(CMD_DRAIN, 32'hFFFF_FFFF));
        dir_tab.push_back(word_row(CMD_PUSH, 32'hFFFF_FFFF));
        dir_tab.push_back(cfg_row(REG_WIDTH, 13'h0));
        dir_tab.push_back(cfg_row(REG_HEIGHT, 13'h0));
        dir_tab.push_back(cfg_row(REG_RADIUS, 13'h0));
        dir_tab.push_back(word_row(CMD_PUSH, 32'h80FF_00FF, 1,
                                   '{8'hFF, 8'h00, 8'hFF, 8'h80, 1'b1, 1'b1}));
        dir_tab.push_back(word_row(CMD_PUSH, 32'h0, 1, '{8'h0, 8'h0, 8'h0, 8'h0, 1'b1, 1'b1}));
        dir_tab.push_back(word_row(CMD_PUSH, 32'hFFFF_FFFF, 1,
                                   '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}));
        dir_tab.push_back(word_row(CMD_DRAIN, 32'h0));
        dir_tab.push_back(cfg_row(2'd3, 13'h0AAA));
        dir_tab.push_back(cfg_row(REG_WIDTH, 13'd3));
        dir_tab.push_back(cfg_row(REG_HEIGHT, 13'd3));
        dir_tab.push_back(cfg_row(REG_RADIUS, 13'd2));
        for (int i = 0; i < 9; i++)
            dir_tab.push_back(word_row(CMD_PUSH, (i % 2) ? 32'hFFFF_FFFF : 32'h0000_00FF * i));
        for (int i = 0; i < 5; i++)
            dir_tab.push_back(word_row(i == 4 ? CMD_PUSH : CMD_DRAIN, 32'h5A5A_5A5A));
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                wait_idle();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end
            else
            begin
                send_word(dir_tab[i].cmd, dir_tab[i].px, dir_tab[i].has_exp, dir_tab[i].exp);
            end
        end

        // random phases of small frames, mostly well formed
        while (n_words < 1200)
        begin
            wait_idle();
            n_phases++;
            case ($urandom_range(0, 9))
                0:
                begin
                    w = 1;
                    h = $urandom_range(1, 8);
                end
                1:
                begin
                    w = $urandom_range(16, 40);
                    h = $urandom_range(1, 2);
                end
                default:
                begin
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 8);
                end
            endcase
            r = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 15) : $urandom_range(0, 4);
            write_reg(REG_RADIUS, 13'(r));
            write_reg(REG_WIDTH, 13'(w));
            write_reg(REG_HEIGHT, 13'(h));
            if (n_phases == 3)
                hold_req = 1'b1;
            frames = $urandom_range(1, 3);
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h) : -1;
            aborted = 1'b0;
            for (int f = 0; f < frames && !aborted; f++)
            begin
                frame_closed = 1'b0;
                while (!frame_closed && !aborted)
                begin
                    if (!frame_in_done)
                        cmd = ($urandom_range(0, 9) == 0) ? CMD_DRAIN : CMD_PUSH;
                    else
                        cmd = ($urandom_range(0, 4) == 0) ? CMD_PUSH : CMD_DRAIN;
                    send_word(cmd, rand_pixel());
                    if (cut > 0 && --cut == 0)
                        aborted = 1'b1;
                    if ($urandom_range(0, 199) == 0)
                    begin
                        s_axis_tvalid <= 1'b0;
                        while (median_q.size() != 0) @(posedge clk);
                        @(posedge clk);
                    end
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (median_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d input words over %0d register settings, %0d results in %0d frames",
                 n_words, n_phases, n_results, n_frames);
        $display("mismatches or stray results: %0d", n_errors);
        if (n_errors == 0 && median_q.size() == 0)
            $display("clamped_window_median_rgb test passed");
        else
            $display("clamped_window_median_rgb test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cwm_pkg.sv
rtl/cwm_line_store.sv
rtl/cwm_bit_select.sv
rtl/clamped_window_median_rgb.sv
tb/sv/tb_top.sv
